// ----- rtl/trajectory_setpoint_interpolator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory setpoint interpolator.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_SETPOINT_INTERPOLATOR_DEFINES_SVH
`define TRAJECTORY_SETPOINT_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tsi_pkg.sv -----
// ----------------------------------------------------------------------------
// tsi_pkg
// Types and constants shared by the trajectory setpoint interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

  // Number of interpolated values in one waypoint.
  localparam int unsigned NVAL   = 10;
  localparam int unsigned FIDX_W = 4;

  // Command codes.
  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_RUN    = 3'd3;
  localparam logic [2:0] ACT_HOLD   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  typedef logic [NVAL-1:0][31:0] vals_t;

  // One table entry: waypoint time and its values.
  typedef struct packed {
    logic [31:0] tm;
    vals_t       vals;
  } wp_t;

  // Tag that travels with a value through the interpolation pipeline.
  typedef struct packed {
    logic              vld;
    logic [FIDX_W-1:0] idx;
  } lerp_tag_t;

endpackage

// ----- rtl/tsi_wp_mem.sv -----
// ----------------------------------------------------------------------------
// tsi_wp_mem
// Waypoint table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsi_wp_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  tsi_pkg::wp_t    wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output tsi_pkg::wp_t    rdata_o
);
  import tsi_pkg::*;

  wp_t mem [DEPTH];
  wp_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tsi_div.sv -----
// ----------------------------------------------------------------------------
// tsi_div
// Restoring divider for the interpolation fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tsi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [30:0] quo_o
);
  import tsi_pkg::*;

  logic        run_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [30:0] quo_q;
  logic        done_q;
  logic [32:0] shl;
  logic        ge;

  // The numerator is below the divisor, so the quotient of num * 2^31 has 31 bits.
  assign shl = {rem_q, 1'b0};
  assign ge  = shl >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift, compare and subtract.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? 32'(shl - {1'b0, den_q}) : shl[31:0];
      quo_q <= {quo_q[29:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/tsi_lerp.sv -----
// ----------------------------------------------------------------------------
// tsi_lerp
// Two-stage interpolation of one value between two waypoints.
// ----------------------------------------------------------------------------
module tsi_lerp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsi_pkg::lerp_tag_t  tag_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  logic [30:0]         alpha_i,
  output tsi_pkg::lerp_tag_t  tag_o,
  output logic [31:0]         res_o
);
  import tsi_pkg::*;

  lerp_tag_t          tag1_q, tag2_q;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic signed [32:0] p0_q;
  logic               neg_q;
  logic [63:0]        prod_q;
  logic [63:0]        rnd;
  logic [32:0]        r;
  logic [33:0]        sum;
  logic [31:0]        res_q;

  // Stage one: magnitude of the difference times the fraction.
  assign diff = $signed({b_i[31], b_i}) - $signed({a_i[31], a_i});
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  // Stage two: round half away from zero and apply the sign.
  assign rnd = prod_q + 64'h4000_0000;
  assign r   = rnd[63:31];
  assign sum = neg_q ? 34'($signed({p0_q[32], p0_q}) - $signed({1'b0, r}))
                     : 34'($signed({p0_q[32], p0_q}) + $signed({1'b0, r}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= $signed({a_i[31], a_i});
    neg_q  <= diff[32];
    prod_q <= 64'(mag) * 64'(alpha_i);
    res_q  <= sum[31:0];
  end

  assign tag_o = tag2_q;
  assign res_o = res_q;

endmodule

// ----- rtl/trajectory_setpoint_interpolator.sv -----
// ----------------------------------------------------------------------------
// trajectory_setpoint_interpolator
// Waypoint table with piecewise-linear setpoint interpolation in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a rising edge with start high and busy low.
//   action_i selects append, tick, stop, run, hold-first or clear; the
//   waypoint fields matter only for append and time_value_i for append and
//   tick. Non-tick commands never raise busy and give no result.
//   A tick while active gives one setpoint word on the set_*_o ports, shown
//   for exactly one cycle with valid_o high; the receiver cannot stall it.
//   Steps of a tick: the accepting edge reads the last waypoint, and a time
//   at or past it shows that point. In hold-first mode the first point is
//   read and shown; else a table walk runs on from the current stage (one
//   table read per cycle); a time before the first waypoint shows the first
//   point, any other reads the lower point, the bit-serial divider forms the
//   fraction when the time lies strictly past that point, and the
//   interpolation pipeline blends the ten values. Busy drops at the edge
//   that raises valid_o, so the next word is taken at the following edge at the earliest.
//   Reset empties the table (count to zero), clears the flags and needs no
//   clearing pass; table contents are undefined until written.
// ----------------------------------------------------------------------------
`include "trajectory_setpoint_interpolator_defines.svh"

module trajectory_setpoint_interpolator #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [31:0] time_value_i,
  input  logic [31:0] way_x_i,
  input  logic [31:0] way_y_i,
  input  logic [31:0] way_z_i,
  input  logic [31:0] way_vx_i,
  input  logic [31:0] way_vy_i,
  input  logic [31:0] way_vz_i,
  input  logic [31:0] way_ax_i,
  input  logic [31:0] way_ay_i,
  input  logic [31:0] way_az_i,
  input  logic [31:0] way_yaw_i,
  output logic        valid_o,
  output logic [31:0] set_x_o,
  output logic [31:0] set_y_o,
  output logic [31:0] set_z_o,
  output logic [31:0] set_vx_o,
  output logic [31:0] set_vy_o,
  output logic [31:0] set_vz_o,
  output logic [31:0] set_ax_o,
  output logic [31:0] set_ay_o,
  output logic [31:0] set_az_o,
  output logic [31:0] set_yaw_o
);
  import tsi_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LAST, S_SEARCH, S_PREV, S_DIV, S_LERP, S_EMIT
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  count_q;
  logic [AW-1:0]  stage_q;
  logic [AW-1:0]  idx_q;
  logic [31:0]    elapsed_q;
  logic           active_q;
  logic           running_q;
  logic [32:0]    next_q;
  wp_t            hi_q;
  vals_t          lo_q;
  vals_t          out_q;
  logic [30:0]    alpha_q;
  logic [FIDX_W-1:0] j_q;
  logic           valid_q;

  logic           accept;
  logic [AW-1:0]  last;
  logic [AW-1:0]  first_idx;
  logic           mem_we;
  wp_t            mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  wp_t            rd;
  logic           past_end;
  logic           advance;
  logic           div_start;
  logic           div_done;
  logic [30:0]    div_quo;
  lerp_tag_t      lerp_in;
  lerp_tag_t      lerp_out;
  logic [31:0]    lerp_res;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign last      = AW'(count_q - CW'(1));
  assign first_idx = (stage_q > last) ? last : stage_q;
  assign past_end  = next_q >= {1'b0, rd.tm};
  assign advance   = (idx_q < last) && ({1'b0, rd.tm} <= next_q);

  // Table write for an append while inactive and not full.
  assign mem_we = accept && (action_i == ACT_APPEND) && !active_q &&
                  (count_q < CW'(TABLE_DEPTH));
  assign mem_wdata.tm   = time_value_i;
  assign mem_wdata.vals = {way_yaw_i, way_az_i, way_ay_i, way_ax_i, way_vz_i,
                           way_vy_i, way_vx_i, way_z_i, way_y_i, way_x_i};

  // Table read requests issued by each state.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && action_i == ACT_TICK && active_q && count_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = last;
        end
      end
      S_LAST: begin
        if (!past_end) begin
          mem_re    = 1'b1;
          mem_raddr = running_q ? first_idx : '0;
        end
      end
      S_SEARCH: begin
        if (advance) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_q + AW'(1));
        end else if (idx_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_q - AW'(1));
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  tsi_wp_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  // Fraction divider, started once both bracketing times are known and the time lies strictly between them.
  assign div_start = (state_q == S_PREV) && (hi_q.tm > rd.tm) &&
                     (next_q > {1'b0, rd.tm});

  tsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (32'(next_q - {1'b0, rd.tm})),
    .den_i   (32'(hi_q.tm - rd.tm)),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // One value enters the interpolation pipeline per cycle.
  assign lerp_in.vld = (state_q == S_LERP) && (j_q < FIDX_W'(NVAL));
  assign lerp_in.idx = j_q;

  tsi_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (lerp_in),
    .a_i     (lo_q[j_q]),
    .b_i     (hi_q.vals[j_q]),
    .alpha_i (alpha_q),
    .tag_o   (lerp_out),
    .res_o   (lerp_res)
  );

  // Sequencer: commands, table walk and result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      stage_q   <= '0;
      idx_q     <= '0;
      elapsed_q <= '0;
      active_q  <= 1'b0;
      running_q <= 1'b0;
      next_q    <= '0;
      j_q       <= '0;
      alpha_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (action_i)
              ACT_APPEND: begin
                if (mem_we) begin
                  count_q <= count_q + CW'(1);
                end
              end
              ACT_TICK: begin
                if (active_q && count_q != '0) begin
                  next_q  <= {1'b0, elapsed_q} + {1'b0, time_value_i};
                  state_q <= S_LAST;
                end
              end
              ACT_STOP: begin
                if (count_q != '0) begin
                  running_q <= 1'b0;
                  active_q  <= 1'b0;
                  elapsed_q <= '0;
                  stage_q   <= '0;
                end
              end
              ACT_RUN: begin
                if (count_q != '0 && !running_q) begin
                  running_q <= 1'b1;
                  active_q  <= 1'b1;
                  elapsed_q <= '0;
                  stage_q   <= '0;
                end
              end
              ACT_HOLD: begin
                if (count_q != '0) begin
                  running_q <= 1'b0;
                  active_q  <= 1'b1;
                  elapsed_q <= '0;
                  stage_q   <= '0;
                end
              end
              ACT_CLEAR: begin
                if (!active_q) begin
                  count_q <= '0;
                end
              end
              default: begin
                count_q <= count_q;
              end
            endcase
          end
        end
        S_LAST: begin
          if (past_end) begin
            out_q     <= rd.vals;
            valid_q   <= 1'b1;
            elapsed_q <= rd.tm;
            stage_q   <= last;
            state_q   <= S_IDLE;
          end else if (!running_q) begin
            elapsed_q <= '0;
            stage_q   <= '0;
            state_q   <= S_EMIT;
          end else begin
            idx_q   <= first_idx;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (advance) begin
            idx_q <= AW'(idx_q + AW'(1));
          end else if (idx_q == '0) begin
            // Time lies before the first waypoint: hold the first point.
            out_q     <= rd.vals;
            valid_q   <= 1'b1;
            stage_q   <= '0;
            elapsed_q <= next_q[31:0];
            state_q   <= S_IDLE;
          end else begin
            hi_q    <= rd;
            state_q <= S_PREV;
          end
        end
        S_PREV: begin
          lo_q      <= rd.vals;
          stage_q   <= AW'(idx_q - AW'(1));
          elapsed_q <= next_q[31:0];
          j_q       <= '0;
          if (div_start) begin
            state_q <= S_DIV;
          end else begin
            alpha_q <= '0;
            state_q <= S_LERP;
          end
        end
        S_DIV: begin
          if (div_done) begin
            alpha_q <= div_quo;
            state_q <= S_LERP;
          end
        end
        S_LERP: begin
          if (j_q < FIDX_W'(NVAL)) begin
            j_q <= j_q + FIDX_W'(1);
          end
          if (lerp_out.vld) begin
            out_q[lerp_out.idx] <= lerp_res;
            if (lerp_out.idx == FIDX_W'(NVAL - 1)) begin
              valid_q <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          out_q   <= rd.vals;
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign valid_o   = valid_q;
  assign set_x_o   = out_q[0];
  assign set_y_o   = out_q[1];
  assign set_z_o   = out_q[2];
  assign set_vx_o  = out_q[3];
  assign set_vy_o  = out_q[4];
  assign set_vz_o  = out_q[5];
  assign set_ax_o  = out_q[6];
  assign set_ay_o  = out_q[7];
  assign set_az_o  = out_q[8];
  assign set_yaw_o = out_q[9];

  // A result word is shown only once the sequencer is back to idle.
  `TSI_ASSERT_NOW(a_valid_idle, valid_q, state_q == S_IDLE, "result while busy")
  // Result words are never shown in back-to-back cycles.
  `TSI_ASSERT_NEXT(a_valid_pulse, valid_q, !valid_q, "result held two cycles")
  // Running implies active.
  `TSI_ASSERT_NOW(a_run_active, running_q, active_q, "running while inactive")
  // Interpolation results emerge only while interpolating.
  `TSI_ASSERT_NOW(a_lerp_state, lerp_out.vld, state_q == S_LERP, "stray lerp output")

endmodule

// ----- test/trajectory_setpoint_interpolator_test.sv -----
// ----------------------------------------------------------------------------
// Trajectory setpoint interpolator testbench
// Drives command words (append, tick, stop, run, hold, clear and the spare
// codes) through the start/busy handshake with random gaps. A built-in model
// of the waypoint table predicts every setpoint word, and a monitor compares
// each word on valid_o with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trajectory_setpoint_interpolator_test;
  import tsi_pkg::*;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned LIMIT     = 3000000;
  localparam int unsigned DRAIN     = 1200;
  localparam int unsigned ITEMS     = 1500;
  localparam logic [2:0]  ACT_SPARE6 = 3'd6;
  localparam logic [2:0]  ACT_SPARE7 = 3'd7;

  // Directed stimulus row; exp_typed marks a hand-written expectation.
  typedef struct {
    logic [2:0]  act;
    logic [31:0] tv;
    vals_t       wv;
    bit          exp_typed;
    vals_t       exp_val;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action_i = '0;
  logic [31:0] time_value_i = '0;
  vals_t       way_v = '0;
  logic        valid_o;
  vals_t       set_v;

  // Model state of the waypoint table.
  logic [31:0] wp_time [DEPTH];
  vals_t       wp_vals [DEPTH];
  int unsigned wp_count;
  int unsigned stage;
  logic [31:0] traj_time;
  bit          active;
  bit          running;

  vals_t       pending_setpoints [$];
  row_t        directed_rows [$];
  int unsigned fails = 0;
  int unsigned cycles = 0;
  int unsigned setpoints_seen = 0;
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;

  string field_name [NVAL] = '{"set_x", "set_y", "set_z", "set_vx", "set_vy", "set_vz",
                               "set_ax", "set_ay", "set_az", "set_yaw"};

  trajectory_setpoint_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .time_value_i(time_value_i),
    .way_x_i     (way_v[0]),
    .way_y_i     (way_v[1]),
    .way_z_i     (way_v[2]),
    .way_vx_i    (way_v[3]),
    .way_vy_i    (way_v[4]),
    .way_vz_i    (way_v[5]),
    .way_ax_i    (way_v[6]),
    .way_ay_i    (way_v[7]),
    .way_az_i    (way_v[8]),
    .way_yaw_i   (way_v[9]),
    .valid_o     (valid_o),
    .set_x_o     (set_v[0]),
    .set_y_o     (set_v[1]),
    .set_z_o     (set_v[2]),
    .set_vx_o    (set_v[3]),
    .set_vy_o    (set_v[4]),
    .set_vz_o    (set_v[5]),
    .set_ax_o    (set_v[6]),
    .set_ay_o    (set_v[7]),
    .set_az_o    (set_v[8]),
    .set_yaw_o   (set_v[9])
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Compare every setpoint word with the oldest prediction.
  always @(posedge clk_i) begin
    vals_t want;
    if (rst_ni && valid_o) begin
      setpoints_seen++;
      if (pending_setpoints.size() == 0) begin
        $error("setpoint word with no prediction waiting");
        fails++;
      end else begin
        want = pending_setpoints.pop_front();
        for (int j = 0; j < NVAL; j++) begin
          if (set_v[j] !== want[j]) begin
            $error("%s: expected %h, got %h", field_name[j], want[j], set_v[j]);
            fails++;
          end
        end
      end
    end
  end

  // Blend two Q16.16 values by a Q0.31 fraction, rounding half away from zero.
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [63:0] frac);
    logic signed [63:0] p0, d, res;
    logic [63:0] mag, r;
    p0 = {{32{a[31]}}, a};
    d = {{32{b[31]}}, b} - p0;
    mag = d < 0 ? -d : d;
    r = (mag * frac + (64'd1 << 30)) >> 31;
    res = d < 0 ? p0 - signed'(r) : p0 + signed'(r);
    return res[31:0];
  endfunction

  // Mode change shared by stop, run and hold.
  task automatic change_mode(input bit to_run, input bit to_active);
    if (wp_count == 0) return;
    if (running && to_run) return;
    running = to_run;
    active = to_active;
    traj_time = '0;
    stage = 0;
  endtask

  // Advance the table model by one command word; yields the setpoint if any.
  task automatic track_setpoint(input logic [2:0] act, input logic [31:0] tv,
                                input vals_t wv, output bit produced, output vals_t sp);
    int unsigned last, i;
    logic [63:0] next, frac, t0, t1;
    produced = 1'b0;
    sp = '0;
    case (act)
      ACT_APPEND: begin
        if (!active && wp_count < DEPTH) begin
          wp_time[wp_count] = tv;
          wp_vals[wp_count] = wv;
          wp_count++;
        end
      end
      ACT_TICK: begin
        if (active && wp_count != 0) begin
          produced = 1'b1;
          last = wp_count - 1;
          next = {32'd0, traj_time} + {32'd0, tv};
          if (next >= {32'd0, wp_time[last]}) begin
            sp = wp_vals[last];
            traj_time = wp_time[last];
            stage = last;
          end else if (!running) begin
            sp = wp_vals[0];
            stage = 0;
            traj_time = '0;
          end else begin
            i = stage > last ? last : stage;
            while (i < last && {32'd0, wp_time[i]} <= next) i++;
            if (i == 0) begin
              sp = wp_vals[0];
              stage = 0;
            end else begin
              t0 = {32'd0, wp_time[i-1]};
              t1 = {32'd0, wp_time[i]};
              frac = '0;
              if (t1 > t0 && next > t0) frac = ((next - t0) << 31) / (t1 - t0);
              for (int j = 0; j < NVAL; j++)
                sp[j] = blend(wp_vals[i-1][j], wp_vals[i][j], frac);
              stage = i - 1;
            end
            traj_time = next[31:0];
          end
        end
      end
      ACT_STOP:  change_mode(1'b0, 1'b0);
      ACT_RUN:   change_mode(1'b1, 1'b1);
      ACT_HOLD:  change_mode(1'b0, 1'b1);
      ACT_CLEAR: if (!active) wp_count = 0;
      default: ;
    endcase
  endtask

  // Idle length between words: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Issue one command word and record its prediction once it is taken.
  task automatic send(input logic [2:0] act, input logic [31:0] tv, input vals_t wv,
                      input bit exp_typed = 1'b0, input vals_t exp_val = '0);
    bit produced;
    vals_t sp;
    int unsigned gap;
    start <= 1'b1;
    action_i <= act;
    time_value_i <= tv;
    way_v <= wv;
    do @(posedge clk_i); while (busy);
    track_setpoint(act, tv, wv, produced, sp);
    if (exp_typed) sp = exp_val;
    if (produced) pending_setpoints.insert(pending_setpoints.size(), sp);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // A Q16.16 word, biased toward the extremes.
  function automatic logic [31:0] any_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7fff_ffff;
    if (r == 2) return 32'h0000_0000;
    return $urandom;
  endfunction

  function automatic vals_t any_point();
    vals_t v;
    for (int j = 0; j < NVAL; j++) v[j] = any_word();
    return v;
  endfunction

  function automatic vals_t flat_point(logic [31:0] w);
    vals_t v;
    for (int j = 0; j < NVAL; j++) v[j] = w;
    return v;
  endfunction

  task automatic add_row(logic [2:0] act, logic [31:0] tv, vals_t wv,
                         bit exp_typed = 1'b0, vals_t exp_val = '0);
    row_t r;
    r.act = act;
    r.tv = tv;
    r.wv = wv;
    r.exp_typed = exp_typed;
    r.exp_val = exp_val;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // One well-formed session: stop, clear, load a table and play it; with some noise.
  task automatic play_session(input int unsigned n_points, input bit use_hold);
    logic [31:0] t;
    logic [31:0] span;
    logic [2:0]  act;
    int unsigned n_ticks;
    send(ACT_STOP, $urandom, any_point());
    send(ACT_CLEAR, $urandom, any_point());
    t = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 5000);
    for (int unsigned k = 0; k < n_points; k++) begin
      send(ACT_APPEND, t, any_point());
      case ($urandom_range(0, 9))
        0:       t = t;
        1:       t = t - $urandom_range(0, 2000);
        2:       t = $urandom;
        default: t = t + $urandom_range(1, 20000);
      endcase
    end
    span = t + 32'd1;
    send(use_hold ? ACT_HOLD : ACT_RUN, $urandom, any_point());
    n_ticks = $urandom_range(3, 25);
    for (int unsigned k = 0; k < n_ticks; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        act = 3'($urandom_range(0, 7));
        send(act, $urandom, any_point());
      end else begin
        case ($urandom_range(0, 19))
          0:       send(ACT_TICK, 32'hffff_ffff, any_point());
          1:       send(ACT_TICK, $urandom, any_point());
          2:       send(ACT_TICK, 32'd0, any_point());
          default: send(ACT_TICK, $urandom_range(0, span / 8 + 1), any_point());
        endcase
      end
    end
  endtask

  initial begin
    vals_t pa, pb, pc;
    logic [31:0] t;

    // Reset once at the start.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wp_count = 0;
    stage = 0;
    traj_time = '0;
    active = 1'b0;
    running = 1'b0;
    @(posedge clk_i);

    // Directed part: extremes, every command, the special cases.
    pa = flat_point(32'h8000_0000);
    pb = flat_point(32'h7fff_ffff);
    pc = any_point();
    add_row(ACT_TICK, 32'd100, pa);
    add_row(ACT_RUN, 32'd0, pa);
    add_row(ACT_HOLD, 32'd0, pa);
    add_row(ACT_STOP, 32'd0, pa);
    add_row(ACT_CLEAR, 32'd0, pa);
    add_row(ACT_APPEND, 32'd1000, pa);
    add_row(ACT_APPEND, 32'd3000, pb);
    add_row(ACT_APPEND, 32'd5000, pc);
    add_row(ACT_HOLD, 32'd0, pa);
    add_row(ACT_TICK, 32'd500, pa, 1'b1, pa);
    add_row(ACT_TICK, 32'hffff_ffff, pa, 1'b1, pc);
    add_row(ACT_RUN, 32'd0, pa);
    add_row(ACT_TICK, 32'd500, pa, 1'b1, pa);
    add_row(ACT_TICK, 32'd1000, pa);
    add_row(ACT_APPEND, 32'd9000, pb);
    add_row(ACT_CLEAR, 32'd0, pa);
    add_row(ACT_RUN, 32'd0, pa);
    add_row(ACT_SPARE6, 32'hffff_ffff, pb);
    add_row(ACT_SPARE7, 32'hffff_ffff, pb);
    add_row(ACT_TICK, 32'd1500, pa);
    add_row(ACT_TICK, 32'hffff_ffff, pa, 1'b1, pc);
    add_row(ACT_STOP, 32'd0, pa);
    add_row(ACT_TICK, 32'd10, pa);
    add_row(ACT_CLEAR, 32'd0, pa);
    foreach (directed_rows[i])
      send(directed_rows[i].act, directed_rows[i].tv, directed_rows[i].wv,
           directed_rows[i].exp_typed, directed_rows[i].exp_val);

    // Full table: the last appends are dropped, ticks search far.
    send(ACT_STOP, 32'd0, pa);
    send(ACT_CLEAR, 32'd0, pa);
    t = 32'd200;
    for (int unsigned k = 0; k < DEPTH + 4; k++) begin
      send(ACT_APPEND, t, any_point());
      t = t + $urandom_range(1, 50);
    end
    send(ACT_RUN, 32'd0, pa);
    for (int unsigned k = 0; k < 6; k++) send(ACT_TICK, $urandom_range(0, 6000), pa);
    send(ACT_TICK, 32'hffff_ffff, pa);

    // Random sessions, some of them back to back without idling.
    while (items_sent < ITEMS) begin
      quiet = $urandom_range(0, 4) == 0;
      play_session($urandom_range(1, 12), $urandom_range(0, 4) == 0);
    end
    quiet = 1'b0;
    start <= 1'b0;

    // Let outstanding setpoints arrive, then allow a full search to finish.
    while (pending_setpoints.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Sent %0d command words; compared %0d setpoint words.",
             items_sent, setpoints_seen);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tsi_pkg.sv
rtl/tsi_wp_mem.sv
rtl/tsi_div.sv
rtl/tsi_lerp.sv
rtl/trajectory_setpoint_interpolator.sv
test/trajectory_setpoint_interpolator_test.sv
